/* rtl/meu_pkg.sv */
// Shared types, widths and the modular add helper for the modular exponentiation unit.
// No dependencies.
package meu_pkg;

    localparam int MOD_WIDTH = 32;
    localparam int EXP_WIDTH = 63;
    localparam int MCNT_W    = $clog2(MOD_WIDTH + 1);
    localparam int ECNT_W    = $clog2(EXP_WIDTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RED  = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [MOD_WIDTH-1:0] addend;
        logic [MOD_WIDTH-1:0] mplier;
        logic [MOD_WIDTH-1:0] modulus;
    } t_mul_req;

    // x + y mod m, x < m and y < m
    function automatic logic [MOD_WIDTH-1:0] add_mod(
        input logic [MOD_WIDTH-1:0] x,
        input logic [MOD_WIDTH-1:0] y,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [MOD_WIDTH-1:0] room;
        room = m - y;
        if (x >= room) begin
            add_mod = x - room;
        end else begin
            add_mod = x + y;
        end
    endfunction

endpackage

/* rtl/modular_exponentiation_unit.sv */
// Top level of the modular exponentiation unit: control, exponent cell chain, multiplier.
// Depends on meu_pkg, meu_exp_cell and meu_mulmod.
//
// Computes base^exponent mod modulus by square-and-multiply, MSB first, over all
// EXP_WIDTH exponent bits. One item at a time: the base is reduced first, then
// each exponent bit takes a squaring and, when set, a multiply, each on the
// single bit-serial modular multiplier. A zero exponent (result 1) or zero
// modulus (result 0) does not use the multiplier.
// The result sits in an output register, so the next item is taken while it waits.
module modular_exponentiation_unit
    import meu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [MOD_WIDTH-1:0] i_base,
    input  logic [EXP_WIDTH-1:0] i_exponent,
    input  logic [MOD_WIDTH-1:0] i_modulus,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MOD_WIDTH-1:0] o_power_mod
);

    t_state               r_state;
    logic [ECNT_W-1:0]    r_ecnt;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_b;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_res;
    logic                 r_out_valid;
    logic [MOD_WIDTH-1:0] r_out;

    t_mul_req             mul_req;
    logic                 mul_done;
    logic [MOD_WIDTH-1:0] mul_res;
    logic                 accept;
    logic                 exp_load;
    logic                 exp_shift;
    logic [EXP_WIDTH-1:0] exp_bits;
    logic                 top_bit;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign top_bit = exp_bits[EXP_WIDTH-1];

    assign exp_load = accept;

    genvar gi;
    generate
        for (gi = 0; gi < EXP_WIDTH; gi++) begin : g_cell
            logic prev;
            if (gi == 0) begin : g_first
                assign prev = 1'b0;
            end else begin : g_rest
                assign prev = exp_bits[gi-1];
            end
            meu_exp_cell u_cell (
                .i_clk      (i_clk),
                .i_load     (exp_load),
                .i_shift    (exp_shift),
                .i_load_bit (i_exponent[gi]),
                .i_prev_bit (prev),
                .o_bit      (exp_bits[gi])
            );
        end
    endgenerate

    meu_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    logic bit_step;
    assign bit_step = mul_done && ((r_state == ST_MUL) || (r_state == ST_SQR && !top_bit));
    assign exp_shift = bit_step;

    always_comb begin
        mul_req         = '0;
        mul_req.modulus = r_mod;
        if (accept) begin
            mul_req.start   = (i_exponent != '0) && (i_modulus != '0);
            mul_req.addend  = MOD_WIDTH'(1);
            mul_req.mplier  = i_base;
            mul_req.modulus = i_modulus;
        end else if (mul_done) begin
            unique case (r_state)
                ST_RED: begin
                    mul_req.start  = 1'b1;
                    mul_req.addend = (r_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                    mul_req.mplier = (r_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                end
                ST_SQR: begin
                    mul_req.start  = top_bit || (r_ecnt != ECNT_W'(1));
                    mul_req.addend = top_bit ? r_b : mul_res;
                    mul_req.mplier = mul_res;
                end
                ST_MUL: begin
                    mul_req.start  = (r_ecnt != ECNT_W'(1));
                    mul_req.addend = mul_res;
                    mul_req.mplier = mul_res;
                end
                default: begin
                    mul_req.start = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ecnt      <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ecnt <= ECNT_W'(EXP_WIDTH);
                        if (i_exponent == '0 || i_modulus == '0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    if (mul_done) begin
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (mul_done) begin
                        if (top_bit) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_ecnt <= r_ecnt - 1'b1;
                            if (r_ecnt == ECNT_W'(1)) begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        r_ecnt <= r_ecnt - 1'b1;
                        r_state <= (r_ecnt == ECNT_W'(1)) ? ST_DONE : ST_SQR;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mod <= i_modulus;
            r_res <= (i_exponent == '0) ? MOD_WIDTH'(1) : '0;
        end else if (mul_done) begin
            if (r_state == ST_RED) begin
                r_b <= mul_res;
            end else begin
                r_acc <= mul_res;
                r_res <= mul_res;
            end
        end
        if (r_state == ST_DONE && (!r_out_valid || i_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_power_mod = r_out;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_RED || r_state == ST_SQR || r_state == ST_MUL))
        else $error("multiplier finished outside a compute state");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done && r_state != ST_RED) |=> (r_acc < r_mod))
        else $error("running value not reduced");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("accepted beat left state idle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_out_valid || i_ready)) |=> (o_valid && o_power_mod == $past(r_res)))
        else $error("result not presented");

endmodule

/* rtl/meu_exp_cell.sv */
// One exponent bit cell of the scan chain.
// Depends on meu_pkg.
module meu_exp_cell
    import meu_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_shift,
    input  logic i_load_bit,
    input  logic i_prev_bit,
    output logic o_bit
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bit <= i_load_bit;
        end else if (i_shift) begin
            r_bit <= i_prev_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

/* rtl/meu_mulmod.sv */
// Bit-serial modular multiplier: one double-and-add step per cycle.
// Depends on meu_pkg.
module meu_mulmod
    import meu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_req             i_req,
    output logic                 o_done,
    output logic [MOD_WIDTH-1:0] o_result
);

    logic                 r_busy;
    logic                 r_done;
    logic [MCNT_W-1:0]    r_cnt;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_mp;
    logic [MOD_WIDTH-1:0] r_add;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] n_acc;
    logic [MOD_WIDTH-1:0] dbl;

    always_comb begin
        dbl   = add_mod(r_acc, r_acc, r_mod);
        n_acc = r_mp[MOD_WIDTH-1] ? add_mod(dbl, r_add, r_mod) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(MOD_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_mp  <= i_req.mplier;
            r_add <= i_req.addend;
            r_mod <= i_req.modulus;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mp  <= {r_mp[MOD_WIDTH-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

/* bench/modular_exponentiation_unit_chk.sv */
// Checker for the modular exponentiation unit: watches both channels, predicts
// base^exponent mod modulus for each input beat and compares result beats. Depends on meu_pkg.
`timescale 1ns / 100ps
module modular_exponentiation_unit_chk
    import meu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_ready_in,
    input  logic [MOD_WIDTH-1:0] i_base,
    input  logic [EXP_WIDTH-1:0] i_exponent,
    input  logic [MOD_WIDTH-1:0] i_modulus,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [MOD_WIDTH-1:0] i_power_mod,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results
);
    logic [MOD_WIDTH-1:0] power_q[$];

    function automatic logic [MOD_WIDTH-1:0] expmod(
        input logic [MOD_WIDTH-1:0] b,
        input logic [EXP_WIDTH-1:0] e,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [63:0] acc;
        logic [63:0] rb;
        if (e == '0) return 1;
        if (m == '0) return 0;
        rb  = 64'(b) % 64'(m);
        acc = 64'd1 % 64'(m);
        for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
            acc = (acc * acc) % 64'(m);
            if (e[i]) acc = (acc * rb) % 64'(m);
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [MOD_WIDTH-1:0] want;
        if (!i_rst_n) begin
            power_q.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && i_ready_in) begin
                power_q.insert(power_q.size(), expmod(i_base, i_exponent, i_modulus));
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (power_q.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("power_mod mismatch: expected none actual %h", i_power_mod);
                    end
                    o_errors <= o_errors + 1;
                end else begin
                    want = power_q.pop_front();
                    if (want !== i_power_mod) begin
                        if (o_errors < 10) begin
                            $display("power_mod mismatch: expected %h actual %h",
                                     want, i_power_mod);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= power_q.size();
        end
    end
endmodule

/* bench/modular_exponentiation_unit_tb.sv */
// Top of the modular exponentiation unit bench: drives directed and random
// beats with random gaps and stalls. Depends on meu_pkg and the checker module.
`timescale 1ns / 100ps
module modular_exponentiation_unit_tb;
    import meu_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [MOD_WIDTH-1:0] i_base;
    logic [EXP_WIDTH-1:0] i_exponent;
    logic [MOD_WIDTH-1:0] i_modulus;
    logic                 o_valid;
    logic                 i_ready;
    logic [MOD_WIDTH-1:0] o_power_mod;
    int                   fail_count;
    int                   pending;
    int                   results;
    int                   sent;
    longint               cycles;

    modular_exponentiation_unit u_top (.*);

    modular_exponentiation_unit_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ready_in  (o_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_power_mod (o_power_mod),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_results   (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 5_000_000) begin
                $display("timeout after %0d cycles", cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls per beat
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 19);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk iff o_valid);
        end
    end

    task automatic send_beat(input logic [MOD_WIDTH-1:0] b, input logic [EXP_WIDTH-1:0] e,
                             input logic [MOD_WIDTH-1:0] m);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        @(posedge i_clk iff o_ready);
        sent++;
    endtask

    function automatic logic [EXP_WIDTH-1:0] rand_exp();
        logic [EXP_WIDTH-1:0] e;
        e = EXP_WIDTH'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: e = e & EXP_WIDTH'(32'hFF);
            1: e = e & EXP_WIDTH'(32'hFFFF_FFFF);
            default: ;
        endcase
        return e;
    endfunction

    function automatic logic [MOD_WIDTH-1:0] rand_mod();
        logic [MOD_WIDTH-1:0] m;
        m = $urandom;
        case ($urandom_range(0, 5))
            0: m = $urandom_range(1, 16);
            1: m = m | 32'h8000_0000;
            default: ;
        endcase
        return (m == '0) ? 1 : m;
    endfunction

    initial begin
        logic [EXP_WIDTH-1:0] emax;
        int wait_n;
        emax       = '1;
        sent       = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_base     = '0;
        i_exponent = '0;
        i_modulus  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(32'd7, '0, 32'd13);
        send_beat(32'hFFFF_FFFF, '0, 32'd1);
        send_beat(32'd5, 63'd3, 32'd1);
        send_beat(32'hFFFF_FFFF, emax, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFE, emax, 32'hFFFF_FFFF);
        send_beat('0, emax, 32'hFFFF_FFFB);
        send_beat('0, '0, 32'hFFFF_FFFB);
        send_beat(32'd2, 63'd1, 32'd1000);
        send_beat(32'd2, 63'd10, 32'd1000);
        send_beat(32'd3, 63'd1 << 62, 32'hFFFF_FFFB);
        send_beat(32'hFFFF_FFFF, 63'd2, 32'd2);
        send_beat(32'd12345, 63'h2AAA_AAAA_AAAA_AAAA, 32'h8000_0001);
        send_beat(32'hAAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555);
        send_beat(32'd1, emax, 32'd97);
        send_beat(32'd97, 63'd5, 32'd97);

        for (int n = 0; n < 125; n++) begin
            send_beat($urandom, rand_exp(), rand_mod());
        end
        i_valid <= 1'b0;

        while (results < sent || pending != 0) begin
            @(posedge i_clk);
        end
        wait_n = 0;
        while (wait_n < 200) begin
            @(posedge i_clk);
            wait_n++;
        end
        $display("%0d beats sent, %0d results checked: zero and full exponents,", sent, results);
        $display("unit and full-width moduli, random gaps and stalls on both sides");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
